### hdl/rws_pkg.sv
package rws_pkg;

	localparam int POP_MAX = 256;
	localparam int IDX_W   = $clog2(POP_MAX);
	localparam int CNT_W   = 9;
	localparam int FIT_W   = 16;
	localparam int TOT_W   = 24;
	localparam int TGT_W   = FIT_W + TOT_W;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SELECT = 1'b1;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [FIT_W-1:0] wr_data;
	} rws_mem_req_t;

endpackage

### hdl/roulette_wheel_selector_core.sv
// Sequence: a rejected write strobes done in the cycle after start; an accepted write goes
// through ST_WRD and ST_WUP, then done. A select goes through ST_MUL and ST_WALK up to the
// crossing entry, or on to ST_FIT when none crosses; the walk reads one store entry per cycle.
// Throughput: one item at a time; start is taken again in the cycle done is high.
// Reset: total and all entries read as zero, active count is 256; no clearing pass.
// The receiver cannot stall: each result word is valid for the single cycle of done.
module roulette_wheel_selector_core import rws_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             kind,
	input  logic [7:0]       entry_index,
	input  logic [15:0]      fitness_value,
	input  logic [15:0]      random_draw,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	output logic             done,
	output logic [7:0]       chosen_index,
	output logic [15:0]      chosen_fitness,
	output logic [23:0]      fitness_total,
	output logic             rejected
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_WRD  = 6'b000010,
		ST_WUP  = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_WALK = 6'b010000,
		ST_FIT  = 6'b100000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] active_count_q;
	logic [CNT_W-1:0] count;
	logic [IDX_W-1:0] idx_q;
	logic [FIT_W-1:0] fit_q;
	logic [FIT_W-1:0] draw_q;
	logic [TOT_W-1:0] total_q;
	logic [TGT_W-1:0] target_q;
	logic [TOT_W-1:0] sum_q;
	logic [IDX_W-1:0] ptr_q;
	logic             done_q;
	logic [7:0]       chosen_index_q;
	logic [FIT_W-1:0] chosen_fitness_q;
	logic             rejected_q;

	rws_mem_req_t     req;
	logic [FIT_W-1:0] rd_data;
	logic [TOT_W-1:0] sum_nxt;
	logic             crossed;
	logic             last;
	logic             accept;

	rws_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	assign count   = (active_count_q > CNT_W'(POP_MAX)) ? CNT_W'(POP_MAX) : active_count_q;
	assign sum_nxt = sum_q + TOT_W'(rd_data);
	assign crossed = {sum_nxt, {FIT_W{1'b0}}} > target_q;
	assign last    = (CNT_W'(ptr_q) + CNT_W'(1)) == count;
	assign accept  = start && (state_q == ST_IDLE);

	assign busy           = (state_q != ST_IDLE);
	assign cfg_ready      = 1'b1;
	assign done           = done_q;
	assign chosen_index   = chosen_index_q;
	assign chosen_fitness = chosen_fitness_q;
	assign fitness_total  = total_q;
	assign rejected       = rejected_q;

	always_comb begin
		req = '0;
		case (state_q)
			ST_WRD: begin
				req.rd_en   = 1'b1;
				req.rd_addr = idx_q;
			end
			ST_WUP: begin
				req.wr_en   = 1'b1;
				req.wr_addr = idx_q;
				req.wr_data = fit_q;
			end
			ST_MUL: begin
				req.rd_en   = 1'b1;
				req.rd_addr = '0;
			end
			ST_WALK: begin
				req.rd_en   = !crossed;
				req.rd_addr = last ? '0 : ptr_q + IDX_W'(1);
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q  <= entry_index;
			fit_q  <= fitness_value;
			draw_q <= random_draw;
		end
		if (state_q == ST_MUL) begin
			target_q <= TGT_W'(draw_q) * TGT_W'(total_q);
		end
		chosen_index_q   <= '0;
		chosen_fitness_q <= '0;
		rejected_q       <= 1'b0;
		case (state_q)
			ST_IDLE: begin
				rejected_q <= accept && (kind == KIND_WRITE)
					&& (CNT_W'(entry_index) >= count);
			end
			ST_WUP: begin
				chosen_fitness_q <= fit_q;
			end
			ST_WALK: begin
				if (crossed) begin
					chosen_index_q   <= 8'(ptr_q);
					chosen_fitness_q <= rd_data;
				end
			end
			ST_FIT: begin
				chosen_fitness_q <= rd_data;
			end
			default: begin
				chosen_index_q <= '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			active_count_q <= CNT_W'(256);
			total_q        <= '0;
			sum_q          <= '0;
			ptr_q          <= '0;
			done_q         <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				active_count_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (kind == KIND_SELECT) begin
							state_q <= ST_MUL;
						end else if (CNT_W'(entry_index) < count) begin
							state_q <= ST_WRD;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_WRD: begin
					state_q <= ST_WUP;
				end
				ST_WUP: begin
					total_q <= total_q + TOT_W'(fit_q) - TOT_W'(rd_data);
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_MUL: begin
					sum_q   <= '0;
					ptr_q   <= '0;
					state_q <= (count == '0) ? ST_FIT : ST_WALK;
				end
				ST_WALK: begin
					sum_q <= sum_nxt;
					ptr_q <= ptr_q + IDX_W'(1);
					if (crossed) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (last) begin
						state_q <= ST_FIT;
					end
				end
				ST_FIT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### hdl/rws_store.sv
module rws_store import rws_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  rws_mem_req_t       req,
	output logic [FIT_W-1:0]   rd_data
);

	logic [FIT_W-1:0]   mem [POP_MAX];
	logic [FIT_W-1:0]   mem_q;
	logic [POP_MAX-1:0] vld_q;
	logic               hit_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			mem_q <= mem[req.rd_addr];
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				hit_q <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_data = hit_q ? mem_q : '0;

endmodule
